[rtl/core/joint_velocity_command_conditioner_assert.svh]
// Assertion macros for the joint velocity command conditioner checker.
// Needs clk_i and rst_ni in the scope of the use.
`ifndef JOINT_VELOCITY_COMMAND_CONDITIONER_ASSERT_SVH
`define JOINT_VELOCITY_COMMAND_CONDITIONER_ASSERT_SVH

// Same-cycle implication, disabled in reset.
`define JVCC_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("jvcc checker: same-cycle property violated");

// Next-cycle implication, disabled in reset.
`define JVCC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("jvcc checker: next-cycle property violated");

`endif

[rtl/core/jvcc_pkg.sv]
// Package for the joint velocity command conditioner: constants, payload types,
// register codes, sequencer states and the averaging reciprocal table. No dependencies.
`default_nettype none

package jvcc_pkg;

  localparam int JOINT_COUNT   = 7;
  localparam int VELOCITY_BITS = 20;
  localparam int AVERAGE_DEPTH = 3;
  localparam int STEP_BITS     = 12;

  localparam int ALPHA_W    = 17;
  localparam int VLIM_W     = 19;
  localparam int ACCEL_W    = 24;
  localparam int CFG_DATA_W = 24;
  localparam int CFG_IDX_W  = 2;

  // Shared multiplier operand width (signed), covers accel, reciprocal and velocity
  localparam int MUL_W       = 26;
  // Fixed-point shift of the averaging reciprocal; sums stay below 2**24
  localparam int RECIP_SHIFT = 24;
  localparam int STEP_W      = 22;

  localparam logic [ALPHA_W-1:0] ONE_Q16    = 17'd65536;
  localparam logic [ALPHA_W-1:0] W_PREV_STD = 17'd19661;
  localparam logic [ALPHA_W-1:0] W_RAW_STD  = 17'd45875;
  localparam logic [ALPHA_W-1:0] GAIN_FAST  = 17'd78643;

  localparam logic               FAST_MODE_RST = 1'b1;
  localparam logic [ALPHA_W-1:0] ALPHA_RST     = 17'd3277;
  localparam logic [VLIM_W-1:0]  VLIM_RST      = 19'd32768;
  localparam logic [ACCEL_W-1:0] ACCEL_RST     = 24'd327680;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FAST_MODE      = 2'd0,
    CFG_BLEND_ALPHA    = 2'd1,
    CFG_VELOCITY_LIMIT = 2'd2,
    CFG_ACCEL_LIMIT    = 2'd3
  } cfg_idx_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LIM,
    ST_STEP,
    ST_HOLD,
    ST_PREV,
    ST_RAW,
    ST_MIX,
    ST_AVG_RD,
    ST_AVG_ACC,
    ST_DIV_MUL,
    ST_DIV_CHK,
    ST_DIV_FIX,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic signed [VELOCITY_BITS-1:0] raw_vel_0;
    logic signed [VELOCITY_BITS-1:0] raw_vel_1;
    logic signed [VELOCITY_BITS-1:0] raw_vel_2;
    logic signed [VELOCITY_BITS-1:0] raw_vel_3;
    logic signed [VELOCITY_BITS-1:0] raw_vel_4;
    logic signed [VELOCITY_BITS-1:0] raw_vel_5;
    logic signed [VELOCITY_BITS-1:0] raw_vel_6;
    logic        [STEP_BITS-1:0]     step_time;
    logic                            zero_request;
  } in_item_t;

  typedef struct packed {
    logic signed [VELOCITY_BITS-1:0] cmd_vel_0;
    logic signed [VELOCITY_BITS-1:0] cmd_vel_1;
    logic signed [VELOCITY_BITS-1:0] cmd_vel_2;
    logic signed [VELOCITY_BITS-1:0] cmd_vel_3;
    logic signed [VELOCITY_BITS-1:0] cmd_vel_4;
    logic signed [VELOCITY_BITS-1:0] cmd_vel_5;
    logic signed [VELOCITY_BITS-1:0] cmd_vel_6;
  } out_item_t;

  // floor(2**24 / n) for n = 1..8; quotient is then off by at most one
  function automatic logic [MUL_W-1:0] recip_q24(input logic [3:0] n);
    logic [MUL_W-1:0] r;
    unique case (n)
      4'd1:    r = 26'd16777216;
      4'd2:    r = 26'd8388608;
      4'd3:    r = 26'd5592405;
      4'd4:    r = 26'd4194304;
      4'd5:    r = 26'd3355443;
      4'd6:    r = 26'd2796202;
      4'd7:    r = 26'd2396745;
      4'd8:    r = 26'd2097152;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

[rtl/core/jvcc_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module jvcc_ram #(
  parameter int WIDTH = 20,
  parameter int DEPTH = 21,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output      logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

[rtl/core/jvcc_mul.sv]
// Shared signed multiplier with a registered product.
// Depends on jvcc_pkg for the operand width.
`default_nettype none

module jvcc_mul (
  input  wire logic                                clk_i,
  input  wire logic signed [jvcc_pkg::MUL_W-1:0]   a_i,
  input  wire logic signed [jvcc_pkg::MUL_W-1:0]   b_i,
  output      logic signed [2*jvcc_pkg::MUL_W-1:0] p_o
);

  logic signed [2*jvcc_pkg::MUL_W-1:0] p_d;

  assign p_d = a_i * b_i;

  always_ff @(posedge clk_i) begin
    p_o <= p_d;
  end

endmodule

`default_nettype wire

[rtl/core/joint_velocity_command_conditioner.sv]
// Joint velocity command conditioner: blend, clamp, slew limit and (fast mode) averaging.
// Input is taken only when idle, so a new vector is accepted only once the last result has
// been loaded into the output register; the shared multiplier and the single averaging RAM
// read port make the joints go one after another. A zero request goes straight to the result.
// Reset (rst_ni low, asynchronous): registers to defaults, last output zero, fill zero.
`default_nettype none

module joint_velocity_command_conditioner #(
  parameter int AVERAGE_DEPTH = jvcc_pkg::AVERAGE_DEPTH
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  // input vector channel
  input  wire logic                               in_valid_i,
  output      logic                               in_ready_o,
  input  wire jvcc_pkg::in_item_t                 in_data_i,
  // result channel
  output      logic                               out_valid_o,
  input  wire logic                               out_ready_i,
  output      jvcc_pkg::out_item_t                out_data_o,
  // configuration write channel
  input  wire logic                               cfg_valid_i,
  output      logic                               cfg_ready_o,
  input  wire logic [jvcc_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  wire logic [jvcc_pkg::CFG_DATA_W-1:0]    cfg_data_i
);

  localparam int VB  = jvcc_pkg::VELOCITY_BITS;
  localparam int JC  = jvcc_pkg::JOINT_COUNT;
  localparam int JW  = $clog2(JC);
  localparam int NW  = $clog2(AVERAGE_DEPTH + 1);
  localparam int SLW = (AVERAGE_DEPTH > 1) ? $clog2(AVERAGE_DEPTH) : 1;
  localparam int RD  = AVERAGE_DEPTH * JC;
  localparam int AW  = (RD > 1) ? $clog2(RD) : 1;
  localparam int MW  = jvcc_pkg::MUL_W;
  localparam int PW  = 2 * MW;
  localparam int WW  = VB + 4;   // working width for clamp, slew and sums
  localparam int RS  = jvcc_pkg::RECIP_SHIFT;
  localparam int SW  = jvcc_pkg::STEP_W;

  localparam logic signed [WW-1:0] VMAX = (WW'(1) <<< (VB - 1)) - WW'(1);
  localparam logic signed [WW-1:0] VMIN = -VMAX - WW'(1);

  // ---------------------------------------------------------------------------
  // State
  // ---------------------------------------------------------------------------
  jvcc_pkg::state_e state_q, state_d;

  logic                             fast_q, fast_d;
  logic [jvcc_pkg::ALPHA_W-1:0]     alpha_q, alpha_d;
  logic [jvcc_pkg::VLIM_W-1:0]      vlim_q, vlim_d;
  logic [jvcc_pkg::ACCEL_W-1:0]     accel_q, accel_d;

  logic signed [VB-1:0]             last_q [JC];
  logic signed [VB-1:0]             last_d [JC];
  logic [JW-1:0]                    j_q, j_d;
  logic                             zero_q, zero_d;
  logic [NW-1:0]                    k_q, k_d;
  logic [NW-1:0]                    n_q, n_d;
  logic [NW-1:0]                    fill_q, fill_d;
  logic [SLW-1:0]                   slot_q, slot_d;
  logic [SLW-1:0]                   rd_slot_q, rd_slot_d;
  logic                             out_valid_q, out_valid_d;

  // payload (no reset)
  logic signed [VB-1:0]             raw_q [JC];
  logic signed [VB-1:0]             raw_d [JC];
  logic signed [VB-1:0]             res_q [JC];
  logic signed [VB-1:0]             res_d [JC];
  logic [jvcc_pkg::STEP_BITS-1:0]   dt_q, dt_d;
  logic [VB-2:0]                    lim_q, lim_d;
  logic [SW-1:0]                    step_q, step_d;
  logic signed [PW-1:0]             acc_q, acc_d;
  logic signed [WW-1:0]             sum_q, sum_d;
  logic [RS-1:0]                    m_q, m_d;
  logic [RS-1:0]                    q0_q, q0_d;
  logic                             neg_q, neg_d;
  jvcc_pkg::out_item_t              out_q, out_d;

  // ---------------------------------------------------------------------------
  // Shared multiplier and averaging store
  // ---------------------------------------------------------------------------
  logic signed [MW-1:0] mul_a, mul_b;
  logic signed [PW-1:0] mul_p;

  jvcc_mul u_mul (
    .clk_i (clk_i),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (mul_p)
  );

  logic          ram_we, ram_re;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [VB-1:0] ram_wdata, ram_rdata;

  jvcc_ram #(
    .WIDTH (VB),
    .DEPTH (RD)
  ) u_avg_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // ---------------------------------------------------------------------------
  // Handshakes and blend weights
  // ---------------------------------------------------------------------------
  logic in_xfer, out_free;
  logic [jvcc_pkg::ALPHA_W-1:0] w_prev, w_raw;

  assign in_ready_o  = (state_q == jvcc_pkg::ST_IDLE);
  assign in_xfer     = in_valid_i && in_ready_o;
  assign out_free    = !out_valid_q || out_ready_i;
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // alpha above one acts as one
  always_comb begin
    if (fast_q) begin
      w_prev = (alpha_q > jvcc_pkg::ONE_Q16) ? jvcc_pkg::ONE_Q16 : alpha_q;
    end else begin
      w_prev = jvcc_pkg::W_PREV_STD;
    end
    w_raw = jvcc_pkg::ONE_Q16 - w_prev;
  end

  // Q16 round, ties toward +inf: floor(p / 2**16 + 0.5)
  logic signed [PW-1:0] prod_rnd, blend, blend_rnd;
  assign prod_rnd  = (mul_p + PW'(32768)) >>> 16;
  assign blend     = acc_q + mul_p;
  assign blend_rnd = (blend + PW'(32768)) >>> 16;

  // ---------------------------------------------------------------------------
  // Per-joint mix: saturate, clamp to limit, slew limit
  // ---------------------------------------------------------------------------
  logic signed [WW-1:0] mix_x, mix_clamp, mix_prev, mix_lim, mix_step, mix_d, mix_slew;
  logic signed [VB-1:0] mix_cur;

  always_comb begin
    if (blend_rnd > PW'(VMAX)) begin
      mix_x = VMAX;
    end else if (blend_rnd < PW'(VMIN)) begin
      mix_x = VMIN;
    end else begin
      mix_x = blend_rnd[WW-1:0];
    end
    mix_lim  = signed'(WW'(lim_q));
    mix_step = signed'(WW'(step_q));
    mix_prev = WW'(last_q[j_q]);
    priority if (mix_x > mix_lim) begin
      mix_clamp = mix_lim;
    end else if (mix_x < -mix_lim) begin
      mix_clamp = -mix_lim;
    end else begin
      mix_clamp = mix_x;
    end
    mix_d = mix_clamp - mix_prev;
    priority if (mix_d > mix_step) begin
      mix_slew = mix_prev + mix_step;
    end else if (mix_d < -mix_step) begin
      mix_slew = mix_prev - mix_step;
    end else begin
      mix_slew = mix_clamp;
    end
    priority if (mix_slew > VMAX) begin
      mix_cur = VMAX[VB-1:0];
    end else if (mix_slew < VMIN) begin
      mix_cur = VMIN[VB-1:0];
    end else begin
      mix_cur = mix_slew[VB-1:0];
    end
  end

  // ---------------------------------------------------------------------------
  // Average divide fix-up: q0 may be one short
  // ---------------------------------------------------------------------------
  logic signed [PW-1:0] div_rem;
  logic [RS:0]          div_q;
  logic signed [WW-1:0] div_sq;
  logic signed [VB-1:0] div_cur;

  always_comb begin
    div_rem = signed'(PW'(m_q)) - mul_p;
    div_q   = (RS + 1)'(q0_q) + (RS + 1)'(div_rem >= signed'(PW'(n_q)));
    div_sq  = neg_q ? -signed'(WW'(div_q)) : signed'(WW'(div_q));
    priority if (div_sq > VMAX) begin
      div_cur = VMAX[VB-1:0];
    end else if (div_sq < VMIN) begin
      div_cur = VMIN[VB-1:0];
    end else begin
      div_cur = div_sq[VB-1:0];
    end
  end

  // ---------------------------------------------------------------------------
  // Sequencer: next state
  // ---------------------------------------------------------------------------
  logic last_joint;
  assign last_joint = (j_q == JW'(JC - 1));

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      jvcc_pkg::ST_IDLE: begin
        if (in_xfer) begin
          state_d = in_data_i.zero_request ? jvcc_pkg::ST_DONE : jvcc_pkg::ST_LIM;
        end
      end
      jvcc_pkg::ST_LIM:  state_d = jvcc_pkg::ST_STEP;
      jvcc_pkg::ST_STEP: state_d = jvcc_pkg::ST_HOLD;
      jvcc_pkg::ST_HOLD: state_d = jvcc_pkg::ST_PREV;
      jvcc_pkg::ST_PREV: state_d = jvcc_pkg::ST_RAW;
      jvcc_pkg::ST_RAW:  state_d = jvcc_pkg::ST_MIX;
      jvcc_pkg::ST_MIX: begin
        priority if (fast_q) begin
          state_d = jvcc_pkg::ST_AVG_RD;
        end else if (last_joint) begin
          state_d = jvcc_pkg::ST_DONE;
        end else begin
          state_d = jvcc_pkg::ST_PREV;
        end
      end
      jvcc_pkg::ST_AVG_RD: begin
        state_d = (k_q == n_q) ? jvcc_pkg::ST_DIV_MUL : jvcc_pkg::ST_AVG_ACC;
      end
      jvcc_pkg::ST_AVG_ACC: state_d = jvcc_pkg::ST_AVG_RD;
      jvcc_pkg::ST_DIV_MUL: state_d = jvcc_pkg::ST_DIV_CHK;
      jvcc_pkg::ST_DIV_CHK: state_d = jvcc_pkg::ST_DIV_FIX;
      jvcc_pkg::ST_DIV_FIX: state_d = last_joint ? jvcc_pkg::ST_DONE : jvcc_pkg::ST_PREV;
      jvcc_pkg::ST_DONE: begin
        if (out_free) begin
          state_d = jvcc_pkg::ST_IDLE;
        end
      end
      default: state_d = jvcc_pkg::ST_IDLE;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Sequencer: datapath control
  // ---------------------------------------------------------------------------
  logic [SLW-1:0] rd_slot_nxt;
  assign rd_slot_nxt = (rd_slot_q == '0) ? SLW'(AVERAGE_DEPTH - 1) : rd_slot_q - SLW'(1);

  always_comb begin
    fast_d      = fast_q;
    alpha_d     = alpha_q;
    vlim_d      = vlim_q;
    accel_d     = accel_q;
    last_d      = last_q;
    j_d         = j_q;
    zero_d      = zero_q;
    k_d         = k_q;
    n_d         = n_q;
    fill_d      = fill_q;
    slot_d      = slot_q;
    rd_slot_d   = rd_slot_q;
    out_valid_d = out_valid_q;
    raw_d       = raw_q;
    res_d       = res_q;
    dt_d        = dt_q;
    lim_d       = lim_q;
    step_d      = step_q;
    acc_d       = acc_q;
    sum_d       = sum_q;
    m_d         = m_q;
    q0_d        = q0_q;
    neg_d       = neg_q;
    out_d       = out_q;
    mul_a       = '0;
    mul_b       = '0;
    ram_we      = 1'b0;
    ram_waddr   = AW'(slot_q) * AW'(JC) + AW'(j_q);
    ram_wdata   = mix_cur;
    ram_re      = 1'b0;
    ram_raddr   = AW'(rd_slot_nxt) * AW'(JC) + AW'(j_q);

    // configuration, taken whenever offered
    if (cfg_valid_i) begin
      unique case (jvcc_pkg::cfg_idx_e'(cfg_index_i))
        jvcc_pkg::CFG_FAST_MODE:      fast_d  = cfg_data_i[0];
        jvcc_pkg::CFG_BLEND_ALPHA:    alpha_d = cfg_data_i[jvcc_pkg::ALPHA_W-1:0];
        jvcc_pkg::CFG_VELOCITY_LIMIT: vlim_d  = cfg_data_i[jvcc_pkg::VLIM_W-1:0];
        jvcc_pkg::CFG_ACCEL_LIMIT:    accel_d = cfg_data_i[jvcc_pkg::ACCEL_W-1:0];
        default: ;
      endcase
    end

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      jvcc_pkg::ST_IDLE: begin
        if (in_xfer) begin
          raw_d[0] = in_data_i.raw_vel_0;
          raw_d[1] = in_data_i.raw_vel_1;
          raw_d[2] = in_data_i.raw_vel_2;
          raw_d[3] = in_data_i.raw_vel_3;
          raw_d[4] = in_data_i.raw_vel_4;
          raw_d[5] = in_data_i.raw_vel_5;
          raw_d[6] = in_data_i.raw_vel_6;
          dt_d     = in_data_i.step_time;
          zero_d   = in_data_i.zero_request;
          j_d      = '0;
          n_d      = (fill_q == NW'(AVERAGE_DEPTH)) ? fill_q : fill_q + NW'(1);
          if (in_data_i.zero_request) begin
            // zero request clears the history but leaves the averaging store alone
            for (int i = 0; i < JC; i++) begin
              last_d[i] = '0;
              res_d[i]  = '0;
            end
          end
        end
      end
      jvcc_pkg::ST_LIM: begin
        mul_a = MW'(vlim_q);
        mul_b = MW'(jvcc_pkg::GAIN_FAST);
      end
      jvcc_pkg::ST_STEP: begin
        mul_a = MW'(accel_q);
        mul_b = MW'(dt_q);
        if (fast_q) begin
          lim_d = (prod_rnd > PW'(VMAX)) ? VMAX[VB-2:0] : prod_rnd[VB-2:0];
        end else begin
          lim_d = (VB - 1)'(vlim_q);
        end
      end
      jvcc_pkg::ST_HOLD: begin
        step_d = prod_rnd[SW-1:0];
      end
      jvcc_pkg::ST_PREV: begin
        mul_a = MW'(w_prev);
        mul_b = MW'(last_q[j_q]);
      end
      jvcc_pkg::ST_RAW: begin
        mul_a = MW'(w_raw);
        mul_b = MW'(raw_q[j_q]);
        acc_d = mul_p;
      end
      jvcc_pkg::ST_MIX: begin
        if (fast_q) begin
          // newest entry goes into the store and seeds the sum
          ram_we    = 1'b1;
          sum_d     = WW'(mix_cur);
          k_d       = NW'(1);
          rd_slot_d = slot_q;
        end else begin
          res_d[j_q]  = mix_cur;
          last_d[j_q] = mix_cur;
          j_d         = j_q + JW'(1);
        end
      end
      jvcc_pkg::ST_AVG_RD: begin
        if (k_q == n_q) begin
          neg_d = sum_q < 0;
          m_d   = RS'(sum_q < 0 ? -sum_q : sum_q) + RS'(n_q >> 1);
        end else begin
          ram_re    = 1'b1;
          rd_slot_d = rd_slot_nxt;
        end
      end
      jvcc_pkg::ST_AVG_ACC: begin
        sum_d = sum_q + WW'(signed'(ram_rdata));
        k_d   = k_q + NW'(1);
      end
      jvcc_pkg::ST_DIV_MUL: begin
        mul_a = MW'(m_q);
        mul_b = jvcc_pkg::recip_q24(4'(n_q));
      end
      jvcc_pkg::ST_DIV_CHK: begin
        q0_d  = mul_p[RS +: RS];
        mul_a = MW'(mul_p[RS +: RS]);
        mul_b = MW'(n_q);
      end
      jvcc_pkg::ST_DIV_FIX: begin
        res_d[j_q]  = div_cur;
        last_d[j_q] = div_cur;
        j_d         = j_q + JW'(1);
      end
      jvcc_pkg::ST_DONE: begin
        if (out_free) begin
          out_d.cmd_vel_0 = res_q[0];
          out_d.cmd_vel_1 = res_q[1];
          out_d.cmd_vel_2 = res_q[2];
          out_d.cmd_vel_3 = res_q[3];
          out_d.cmd_vel_4 = res_q[4];
          out_d.cmd_vel_5 = res_q[5];
          out_d.cmd_vel_6 = res_q[6];
          out_valid_d     = 1'b1;
          if (fast_q && !zero_q) begin
            fill_d = n_q;
            slot_d = (slot_q == SLW'(AVERAGE_DEPTH - 1)) ? '0 : slot_q + SLW'(1);
          end
        end
      end
      default: ;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= jvcc_pkg::ST_IDLE;
      fast_q      <= jvcc_pkg::FAST_MODE_RST;
      alpha_q     <= jvcc_pkg::ALPHA_RST;
      vlim_q      <= jvcc_pkg::VLIM_RST;
      accel_q     <= jvcc_pkg::ACCEL_RST;
      for (int i = 0; i < JC; i++) begin
        last_q[i] <= '0;
      end
      j_q         <= '0;
      zero_q      <= 1'b0;
      k_q         <= '0;
      n_q         <= '0;
      fill_q      <= '0;
      slot_q      <= '0;
      rd_slot_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      fast_q      <= fast_d;
      alpha_q     <= alpha_d;
      vlim_q      <= vlim_d;
      accel_q     <= accel_d;
      last_q      <= last_d;
      j_q         <= j_d;
      zero_q      <= zero_d;
      k_q         <= k_d;
      n_q         <= n_d;
      fill_q      <= fill_d;
      slot_q      <= slot_d;
      rd_slot_q   <= rd_slot_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    raw_q  <= raw_d;
    res_q  <= res_d;
    dt_q   <= dt_d;
    lim_q  <= lim_d;
    step_q <= step_d;
    acc_q  <= acc_d;
    sum_q  <= sum_d;
    m_q    <= m_d;
    q0_q   <= q0_d;
    neg_q  <= neg_d;
    out_q  <= out_d;
  end

endmodule

`default_nettype wire

[rtl/core/jvcc_checker.sv]
// Port-level checker for the joint velocity command conditioner, bound to the top level.
// Depends on jvcc_pkg and joint_velocity_command_conditioner_assert.svh.
`default_nettype none

`include "joint_velocity_command_conditioner_assert.svh"

module jvcc_checker (
  input wire logic                            clk_i,
  input wire logic                            rst_ni,
  input wire logic                            in_valid_i,
  input wire logic                            in_ready_o,
  input wire logic                            out_valid_o,
  input wire logic                            out_ready_i,
  input wire jvcc_pkg::out_item_t             out_data_o
);

  // a vector keeps the block busy after its transfer
  `JVCC_ASSERT_NEXT(a_busy_after_transfer, in_valid_i && in_ready_o, !in_ready_o)

  // a fresh result appears exactly as the block frees up
  `JVCC_ASSERT_SAME(a_result_frees_input, $rose(out_valid_o), in_ready_o && !$past(in_ready_o))

  // stalled result holds
  `JVCC_ASSERT_NEXT(a_result_holds, out_valid_o && !out_ready_i, out_valid_o && $stable(out_data_o))

endmodule

bind joint_velocity_command_conditioner jvcc_checker u_jvcc_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);

`default_nettype wire
